// ----- sv/mitcp_pkg.sv -----
package mitcp_pkg;

  // widths of the fixed fields
  localparam int unsigned XW       = 32;  // input value
  localparam int unsigned LimW     = 31;  // limit register
  localparam int unsigned IdW      = 11;  // frame identifier
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 2;

  localparam int unsigned PosBits   = 16;
  localparam int unsigned OtherBits = 12;

  // quotient bits per lane, one pipeline stage each
  localparam int unsigned DivSteps = PosBits;

  // span and numerator widths: 2*limit < 2^32, 500 << 24 < 2^33
  localparam int unsigned SW = 34;
  localparam int unsigned NW = SW + DivSteps;

  localparam int unsigned KpMax = 500;
  localparam int unsigned KdMax = 5;

  localparam int unsigned InDataW  = 5 * XW;
  localparam int unsigned OutUsedW = IdW + 8 * 8;
  localparam int unsigned OutDataW = ((OutUsedW + 7) / 8) * 8;

  localparam logic [IdW-1:0]  SendIdRst  = IdW'(1);
  localparam logic [LimW-1:0] PosLimRst  = LimW'(819200);
  localparam logic [LimW-1:0] VelLimRst  = LimW'(1966080);
  localparam logic [LimW-1:0] TorqLimRst = LimW'(655360);

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEND_ID      = 2'd0,
    REG_POS_LIMIT    = 2'd1,
    REG_VEL_LIMIT    = 2'd2,
    REG_TORQUE_LIMIT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [PosBits-1:0]   pos;
    logic [OtherBits-1:0] vel;
    logic [OtherBits-1:0] stiff;
    logic [OtherBits-1:0] damp;
    logic [OtherBits-1:0] torque;
  } codes_t;

endpackage

// ----- sv/mit_motor_command_frame_packer_unit.sv -----
// an accepted input word passes a clamp stage, a numerator stage and the
// 16-stage restoring divider in each lane (one quotient bit per stage), then
// the output register; throughput: one word per cycle, but
// the whole pipeline holds while a finished frame waits on m_axis_tready
// reset: limits and send id return to their defaults, pipeline emptied
module mit_motor_command_frame_packer_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // target_pos, target_vel, feed_torque, stiff_gain, damp_gain, 32 bits each
  input  logic [mitcp_pkg::InDataW-1:0]         s_axis_tdata,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // frame_id, byte0 .. byte7, zero pad
  output logic [mitcp_pkg::OutDataW-1:0]        m_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mitcp_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [mitcp_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned SW = mitcp_pkg::SW;
  localparam int unsigned XW = mitcp_pkg::XW;
  localparam int unsigned LimW = mitcp_pkg::LimW;
  localparam int unsigned IdW = mitcp_pkg::IdW;
  localparam int unsigned Lat = mitcp_pkg::DivSteps + 2;

  localparam logic [SW-1:0] KpHi = SW'(mitcp_pkg::KpMax) << FRAC_BITS;
  localparam logic [SW-1:0] KdHi = SW'(mitcp_pkg::KdMax) << FRAC_BITS;

  logic [IdW-1:0]  send_id_q;
  logic [LimW-1:0] pos_lim_q;
  logic [LimW-1:0] vel_lim_q;
  logic [LimW-1:0] torq_lim_q;

  logic            adv;
  logic [Lat-1:0]  vld_q;
  logic [Lat-1:0]  vld_d;
  logic            accept;

  logic [LimW-1:0] pos_lim;
  logic [LimW-1:0] vel_lim;
  logic [LimW-1:0] torq_lim;

  mitcp_pkg::codes_t codes;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_id_q  <= mitcp_pkg::SendIdRst;
      pos_lim_q  <= mitcp_pkg::PosLimRst;
      vel_lim_q  <= mitcp_pkg::VelLimRst;
      torq_lim_q <= mitcp_pkg::TorqLimRst;
    end else if (cfg_valid_i) begin
      unique case (mitcp_pkg::cfg_reg_e'(cfg_index_i))
        mitcp_pkg::REG_SEND_ID:      send_id_q  <= cfg_data_i[IdW-1:0];
        mitcp_pkg::REG_POS_LIMIT:    pos_lim_q  <= cfg_data_i[LimW-1:0];
        mitcp_pkg::REG_VEL_LIMIT:    vel_lim_q  <= cfg_data_i[LimW-1:0];
        mitcp_pkg::REG_TORQUE_LIMIT: torq_lim_q <= cfg_data_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  // a zero limit acts as the smallest legal limit
  assign pos_lim  = (pos_lim_q == '0)  ? LimW'(1) : pos_lim_q;
  assign vel_lim  = (vel_lim_q == '0)  ? LimW'(1) : vel_lim_q;
  assign torq_lim = (torq_lim_q == '0) ? LimW'(1) : torq_lim_q;

  assign s_axis_tready = adv;
  assign accept = s_axis_tvalid && s_axis_tready;

  assign vld_d = {vld_q[Lat-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  mitcp_lane #(.CodeBits(mitcp_pkg::PosBits)) u_pos (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .x_i    (signed'(s_axis_tdata[0*XW +: XW])),
    .lo_i   (-signed'(SW'(pos_lim))),
    .hi_i   (signed'(SW'(pos_lim))),
    .span_i (SW'({pos_lim, 1'b0})),
    .code_o (codes.pos)
  );

  mitcp_lane #(.CodeBits(mitcp_pkg::OtherBits)) u_vel (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .x_i    (signed'(s_axis_tdata[1*XW +: XW])),
    .lo_i   (-signed'(SW'(vel_lim))),
    .hi_i   (signed'(SW'(vel_lim))),
    .span_i (SW'({vel_lim, 1'b0})),
    .code_o (codes.vel)
  );

  mitcp_lane #(.CodeBits(mitcp_pkg::OtherBits)) u_torque (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .x_i    (signed'(s_axis_tdata[2*XW +: XW])),
    .lo_i   (-signed'(SW'(torq_lim))),
    .hi_i   (signed'(SW'(torq_lim))),
    .span_i (SW'({torq_lim, 1'b0})),
    .code_o (codes.torque)
  );

  mitcp_lane #(.CodeBits(mitcp_pkg::OtherBits)) u_stiff (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .x_i    (signed'(s_axis_tdata[3*XW +: XW])),
    .lo_i   ('0),
    .hi_i   (signed'(KpHi)),
    .span_i (KpHi),
    .code_o (codes.stiff)
  );

  mitcp_lane #(.CodeBits(mitcp_pkg::OtherBits)) u_damp (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .x_i    (signed'(s_axis_tdata[4*XW +: XW])),
    .lo_i   ('0),
    .hi_i   (signed'(KdHi)),
    .span_i (KdHi),
    .code_o (codes.damp)
  );

  mitcp_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (vld_q[Lat-1]),
    .codes_i       (codes),
    .send_id_i     (send_id_q),
    .adv_o         (adv),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> vld_q[0])
    else $error("accepted word did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[Lat-1]))
    else $error("frame appeared without a finished word");

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output blocked");

endmodule

// ----- sv/mitcp_lane.sv -----
module mitcp_lane #(
  parameter int unsigned CodeBits = 12
) (
  input  logic                                clk_i,
  input  logic                                adv_i,
  input  logic signed [mitcp_pkg::XW-1:0]     x_i,
  input  logic signed [mitcp_pkg::SW-1:0]     lo_i,
  input  logic signed [mitcp_pkg::SW-1:0]     hi_i,
  input  logic        [mitcp_pkg::SW-1:0]     span_i,
  output logic        [CodeBits-1:0]          code_o
);

  localparam int unsigned SW = mitcp_pkg::SW;
  localparam int unsigned NW = mitcp_pkg::NW;
  localparam int unsigned XW = mitcp_pkg::XW;
  localparam int unsigned DivSteps = mitcp_pkg::DivSteps;

  logic signed [SW-1:0] x_ext;
  logic signed [SW-1:0] x_clamp;
  logic        [SW-1:0] off_d;
  logic        [SW-1:0] off_q;
  logic        [NW-1:0] num_d;

  logic [NW-1:0]       rem_q [DivSteps];
  logic [DivSteps-1:0] quo_q [DivSteps+1];

  always_comb begin
    x_ext = signed'({{(SW-XW){x_i[XW-1]}}, x_i});
    if (x_ext < lo_i) begin
      x_clamp = lo_i;
    end else if (x_ext > hi_i) begin
      x_clamp = hi_i;
    end else begin
      x_clamp = x_ext;
    end
    off_d = SW'(x_clamp - lo_i);
  end

  // offset times (2^bits - 1) as a shift and a subtract
  assign num_d = (NW'(off_q) << CodeBits) - NW'(off_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      off_q    <= off_d;
      rem_q[0] <= num_d;
      quo_q[0] <= '0;
    end
  end

  // restoring division, one quotient bit per stage from the top
  for (genvar k = 1; k <= DivSteps; k++) begin : g_div
    localparam int unsigned Bit = DivSteps - k;
    logic [NW-1:0]       dsh;
    logic                ge;
    logic [DivSteps-1:0] quo_d;

    always_comb begin
      dsh        = NW'(span_i) << Bit;
      ge         = rem_q[k-1] >= dsh;
      quo_d      = quo_q[k-1];
      quo_d[Bit] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        quo_q[k] <= quo_d;
      end
    end

    if (k < DivSteps) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[k] <= ge ? rem_q[k-1] - dsh : rem_q[k-1];
        end
      end
    end
  end

  assign code_o = quo_q[DivSteps][CodeBits-1:0];

endmodule

// ----- sv/mitcp_merge.sv -----
module mitcp_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  mitcp_pkg::codes_t                  codes_i,
  input  logic [mitcp_pkg::IdW-1:0]          send_id_i,
  output logic                               adv_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [mitcp_pkg::OutDataW-1:0]     m_axis_tdata
);

  localparam int unsigned OutDataW = mitcp_pkg::OutDataW;
  localparam int unsigned OutUsedW = mitcp_pkg::OutUsedW;

  logic                vld_q;
  logic [OutDataW-1:0] data_q;
  logic [OutDataW-1:0] data_d;
  logic [7:0]          bytes_d [8];

  assign adv_o = !vld_q || m_axis_tready;

  always_comb begin
    bytes_d[0] = codes_i.pos[15:8];
    bytes_d[1] = codes_i.pos[7:0];
    bytes_d[2] = codes_i.vel[11:4];
    bytes_d[3] = {codes_i.vel[3:0], codes_i.stiff[11:8]};
    bytes_d[4] = codes_i.stiff[7:0];
    bytes_d[5] = codes_i.damp[11:4];
    bytes_d[6] = {codes_i.damp[3:0], codes_i.torque[11:8]};
    bytes_d[7] = codes_i.torque[7:0];
    data_d = {{(OutDataW-OutUsedW){1'b0}},
              bytes_d[7], bytes_d[6], bytes_d[5], bytes_d[4],
              bytes_d[3], bytes_d[2], bytes_d[1], bytes_d[0], send_id_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;

endmodule
